/* hdl/stfs_pkg.sv */
// Shared types, codes and defaults for the slot table with free stack.
`default_nettype none

package stfs_pkg;

   localparam int CAPACITY_DEF   = 256;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 8;
   localparam int ENTRY_W  = 32;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd3;

   typedef struct packed {
      logic                return_entry;
      logic [ENTRY_W-1:0]  entry_data;
      logic [INDEX_W-1:0]  slot_index;
      logic [MODE_W-1:0]   mode;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  result_data;
      logic [INDEX_W-1:0]  result_index;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/stfs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module stfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/stfs_rsp_reg.sv */
// Output register for the response channel.
`default_nettype none

module stfs_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire stfs_pkg::rsp_type load_rsp,
   output logic                   free,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output stfs_pkg::rsp_type      rsp
);

   logic              valid_ff;
   logic              valid_in;
   stfs_pkg::rsp_type rsp_ff;

   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= load_rsp;
      end
   end

endmodule

`default_nettype wire

/* hdl/stfs_engine.sv */
// Request sequencer: reads slot and stack memories, updates counters, writes back.
`default_nettype none

module stfs_engine #(
   parameter int CAPACITY   = stfs_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = stfs_pkg::DATA_WIDTH_DEF,
   localparam int IW = $clog2(CAPACITY),
   localparam int SW = DATA_WIDTH + 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire stfs_pkg::req_type req,
   output logic                   req_ready,
   output logic                   slot_rd_en,
   output logic [IW-1:0]          slot_rd_addr,
   input  wire logic [SW-1:0]     slot_rd_data,
   output logic                   slot_wr_en,
   output logic [IW-1:0]          slot_wr_addr,
   output logic [SW-1:0]          slot_wr_data,
   output logic                   stack_rd_en,
   output logic [IW-1:0]          stack_rd_addr,
   input  wire logic [IW-1:0]     stack_rd_data,
   output logic                   stack_wr_en,
   output logic [IW-1:0]          stack_wr_addr,
   output logic [IW-1:0]          stack_wr_data,
   input  wire logic              rsp_free,
   output logic                   rsp_load,
   output stfs_pkg::rsp_type      rsp
);

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > stfs_pkg::INDEX_W) ? CW : stfs_pkg::INDEX_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic                            state_ff, state_in;
   logic [CW-1:0]                   used_count_ff, used_count_in;
   logic [CW-1:0]                   free_depth_ff, free_depth_in;
   logic [stfs_pkg::MODE_W-1:0]     mode_ff;
   logic [stfs_pkg::INDEX_W-1:0]    idx_ff;
   logic [DATA_WIDTH-1:0]           data_ff;
   logic                            give_ff;

   logic                            accept;
   logic                            finish;
   logic [IW-1:0]                   slot_idx;
   logic                            in_range;
   logic                            is_top;
   logic                            slot_valid;
   logic [DATA_WIDTH-1:0]           slot_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == ST_LOOKUP) && rsp_free;

   // Reads go out as the request is taken; data is back in the lookup cycle.
   assign slot_rd_en    = accept;
   assign slot_rd_addr  = IW'(req.slot_index);
   assign stack_rd_en   = accept;
   assign stack_rd_addr = IW'(free_depth_ff - 1'b1);

   assign slot_idx   = IW'(idx_ff);
   assign in_range   = CMP_W'(idx_ff) < CMP_W'(used_count_ff);
   assign is_top     = CMP_W'(idx_ff) == CMP_W'(used_count_ff - 1'b1);
   assign slot_valid = slot_rd_data[DATA_WIDTH];
   assign slot_data  = slot_rd_data[DATA_WIDTH-1:0];

   always_comb begin
      state_in      = state_ff;
      used_count_in = used_count_ff;
      free_depth_in = free_depth_ff;
      slot_wr_en    = 1'b0;
      slot_wr_addr  = slot_idx;
      slot_wr_data  = {1'b1, data_ff};
      stack_wr_en   = 1'b0;
      stack_wr_addr = IW'(free_depth_ff);
      stack_wr_data = slot_idx;
      rsp_load      = finish;
      rsp.result_index = idx_ff;
      rsp.result_data  = '0;
      rsp.status       = stfs_pkg::STATUS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (finish) begin
               state_in = ST_IDLE;
               if (mode_ff == stfs_pkg::MODE_ADD) begin
                  priority if (free_depth_ff != '0) begin
                     free_depth_in    = free_depth_ff - 1'b1;
                     slot_wr_en       = 1'b1;
                     slot_wr_addr     = stack_rd_data;
                     rsp.result_index = stfs_pkg::INDEX_W'(stack_rd_data);
                  end else if (used_count_ff < CAP_C) begin
                     used_count_in    = used_count_ff + 1'b1;
                     slot_wr_en       = 1'b1;
                     slot_wr_addr     = IW'(used_count_ff);
                     rsp.result_index = stfs_pkg::INDEX_W'(used_count_ff);
                  end else begin
                     rsp.result_index = '0;
                     rsp.status       = stfs_pkg::STATUS_FULL;
                  end
               end else if (mode_ff != stfs_pkg::MODE_NONE) begin
                  priority if (!in_range) begin
                     rsp.status = stfs_pkg::STATUS_RANGE;
                  end else if (!slot_valid) begin
                     rsp.status = stfs_pkg::STATUS_ABSENT;
                  end else if (mode_ff == stfs_pkg::MODE_GET) begin
                     rsp.result_data = stfs_pkg::ENTRY_W'(slot_data);
                  end else begin
                     if (give_ff) begin
                        rsp.result_data = stfs_pkg::ENTRY_W'(slot_data);
                     end
                     slot_wr_en   = 1'b1;
                     slot_wr_data = '0;
                     priority if (is_top) begin
                        used_count_in = used_count_ff - 1'b1;
                     end else if (free_depth_ff < CAP_C) begin
                        stack_wr_en   = 1'b1;
                        free_depth_in = free_depth_ff + 1'b1;
                     end else begin
                        free_depth_in = free_depth_ff;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_count_ff <= '0;
         free_depth_ff <= '0;
      end else begin
         state_ff      <= state_in;
         used_count_ff <= used_count_in;
         free_depth_ff <= free_depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req.mode;
         idx_ff  <= req.slot_index;
         data_ff <= DATA_WIDTH'(req.entry_data);
         give_ff <= req.return_entry;
      end
   end

endmodule

`default_nettype wire

/* hdl/slot_table_with_free_stack.sv */
// Slot table with free stack: handle allocator over CAPACITY slots.
// Requests arrive on req_*; one response per request leaves on rsp_*.
// A request is add (store entry in the most recently freed slot, else at the
// count, else report full), get (read an occupied slot) or remove (clear a
// slot, optionally returning its entry; the top slot shrinks the count, any
// other is pushed on the free stack). Unknown modes echo the slot, status ok.
// Each request passes an idle step that reads the slot memory and the free
// stack top, then a lookup step that checks, writes back and loads the
// response register. The engine works on one request at a time, so a new
// request is taken only once the last one has left the lookup step.
// The response register lets the next request in while a response waits;
// if the receiver stalls, the following request is held in the lookup stage
// until the register drains, and req_tready stays low meanwhile.
// Reset clears the count, the free stack depth and all handshake state; the
// memories need no clearing, as slot contents are only used below the count.
`default_nettype none

module slot_table_with_free_stack #(
   parameter int CAPACITY   = stfs_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = stfs_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // mode[1:0], slot_index[9:2], entry_data[41:10], return_entry[42], zero pad
   input  wire logic [stfs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // result_index[7:0], result_data[39:8], status[41:40], zero pad
   output logic      [stfs_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int IW = $clog2(CAPACITY);
   localparam int SW = DATA_WIDTH + 1;
   localparam int REQ_BITS = $bits(stfs_pkg::req_type);
   localparam int RSP_BITS = $bits(stfs_pkg::rsp_type);

   stfs_pkg::req_type req;
   stfs_pkg::rsp_type eng_rsp;
   stfs_pkg::rsp_type out_rsp;

   logic          slot_rd_en, slot_wr_en;
   logic [IW-1:0] slot_rd_addr, slot_wr_addr;
   logic [SW-1:0] slot_rd_data, slot_wr_data;
   logic          stack_rd_en, stack_wr_en;
   logic [IW-1:0] stack_rd_addr, stack_wr_addr, stack_rd_data, stack_wr_data;
   logic          rsp_free, rsp_load;

   assign req       = stfs_pkg::req_type'(req_tdata[REQ_BITS-1:0]);
   assign rsp_tdata = {{(stfs_pkg::RSP_TDATA_W - RSP_BITS){1'b0}}, out_rsp};

   stfs_engine #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req           (req),
      .req_ready     (req_tready),
      .slot_rd_en    (slot_rd_en),
      .slot_rd_addr  (slot_rd_addr),
      .slot_rd_data  (slot_rd_data),
      .slot_wr_en    (slot_wr_en),
      .slot_wr_addr  (slot_wr_addr),
      .slot_wr_data  (slot_wr_data),
      .stack_rd_en   (stack_rd_en),
      .stack_rd_addr (stack_rd_addr),
      .stack_rd_data (stack_rd_data),
      .stack_wr_en   (stack_wr_en),
      .stack_wr_addr (stack_wr_addr),
      .stack_wr_data (stack_wr_data),
      .rsp_free      (rsp_free),
      .rsp_load      (rsp_load),
      .rsp           (eng_rsp)
   );

   // Slot memory: valid bit on top of the entry.
   stfs_ram #(
      .WIDTH (SW),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   stfs_ram #(
      .WIDTH (IW),
      .DEPTH (CAPACITY)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_wr_addr),
      .wr_data (stack_wr_data),
      .rd_en   (stack_rd_en),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   stfs_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_rsp  (eng_rsp),
      .free      (rsp_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (out_rsp)
   );

`ifndef SYNTHESIS
   // One request in flight: intake closes right after a request is taken.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   // A free-stack push only accompanies a remove that clears the slot.
   a_push_on_remove: assert property (@(posedge clock) disable iff (reset)
      stack_wr_en |-> slot_wr_en && !slot_wr_data[DATA_WIDTH])
      else $error("free stack push without slot clear");

   // Memory write-back happens only in the lookup cycle, with a response loaded.
   a_write_in_lookup: assert property (@(posedge clock) disable iff (reset)
      slot_wr_en |-> !req_tready && rsp_load)
      else $error("slot write outside lookup");
`endif

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the slot table with free stack.
`timescale 1ns / 100ps

module tb;
   import stfs_pkg::*;

   localparam int SLOTS = CAPACITY_DEF;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Predicted table contents, kept in step with accepted requests
   logic [ENTRY_W-1:0] slot_data [SLOTS];
   bit                 slot_busy [SLOTS];
   logic [INDEX_W-1:0] free_slots [SLOTS];
   int                 free_top;
   int                 high_water;

   rsp_type pending_rsp [$];
   int      error_count;
   int      op_count [4];
   int      status_count [4];
   int      input_stall_cycles;
   bit      no_idle;
   int      hold_off_len;

   slot_table_with_free_stack dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Updates the predicted table and returns the response a request should produce.
   function automatic rsp_type apply_table_op(req_type r);
      rsp_type o;
      int      slot;
      o              = '0;
      o.result_index = r.slot_index;
      o.status       = STATUS_OK;
      case (r.mode)
         MODE_ADD: begin
            if (free_top > 0) begin
               free_top--;
               slot = int'(free_slots[free_top]);
            end else if (high_water < SLOTS) begin
               slot = high_water;
               high_water++;
            end else begin
               o.result_index = '0;
               o.status       = STATUS_FULL;
               return o;
            end
            slot_data[slot] = r.entry_data;
            slot_busy[slot] = 1'b1;
            o.result_index  = slot[INDEX_W-1:0];
         end
         MODE_NONE: ;
         default: begin
            if (int'(r.slot_index) >= high_water) begin
               o.status = STATUS_RANGE;
            end else if (!slot_busy[r.slot_index]) begin
               o.status = STATUS_ABSENT;
            end else if (r.mode == MODE_GET) begin
               o.result_data = slot_data[r.slot_index];
            end else begin
               if (r.return_entry) o.result_data = slot_data[r.slot_index];
               slot_busy[r.slot_index] = 1'b0;
               slot_data[r.slot_index] = '0;
               // top slot shrinks the count; anything below goes on the free stack
               if (int'(r.slot_index) + 1 == high_water) begin
                  high_water--;
               end else if (free_top < SLOTS) begin
                  free_slots[free_top] = r.slot_index;
                  free_top++;
               end
            end
         end
      endcase
      return o;
   endfunction

   function automatic int idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic int sender_gap();
      if (no_idle || $urandom_range(0, 99) < 55) return 0;
      return idle_len();
   endfunction

   // Mostly occupied slots, then the top slot, freed slots, and anything at all.
   function automatic int pick_slot_index();
      int r;
      int start;
      int s;
      r = $urandom_range(0, 99);
      if (high_water > 0 && r < 60) begin
         start = $urandom_range(0, high_water - 1);
         for (int k = 0; k < high_water; k++) begin
            s = (start + k) % high_water;
            if (slot_busy[s]) return s;
         end
      end
      if (high_water > 0 && r < 75) return high_water - 1;
      if (free_top > 0 && r < 85) return int'(free_slots[$urandom_range(0, free_top - 1)]);
      return $urandom_range(0, SLOTS - 1);
   endfunction

   // Called at a rising edge; returns at the edge where the request was taken.
   task automatic send_request(input logic [MODE_W-1:0] mode, input int idx,
                               input logic [ENTRY_W-1:0] data, input logic ret);
      req_type r;
      rsp_type want;
      int      gap;
      r.mode         = mode;
      r.slot_index   = idx[INDEX_W-1:0];
      r.entry_data   = data;
      r.return_entry = ret;
      gap            = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - $bits(req_type)){1'b0}}, r};
      do @(posedge clock); while (!req_tready);
      want = apply_table_op(r);
      pending_rsp.push_back(want);
      op_count[mode]++;
      status_count[want.status]++;
   endtask

   task automatic random_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         send_request(MODE_ADD, $urandom_range(0, 255), $urandom, 1'($urandom_range(0, 1)));
      else if (r < 70)
         send_request(MODE_GET, pick_slot_index(), $urandom, 1'($urandom_range(0, 1)));
      else if (r < 95)
         send_request(MODE_REMOVE, pick_slot_index(), $urandom, 1'($urandom_range(0, 1)));
      else
         send_request(MODE_NONE, $urandom_range(0, 255), $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_for_responses();
      while (pending_rsp.size() > 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(MODE_GET,    0,   32'h0000_0000, 1'b0);  // empty table: range
      send_request(MODE_REMOVE, 5,   32'hFFFF_FFFF, 1'b1);
      send_request(MODE_NONE,   8'hAA, 32'h5555_AAAA, 1'b0);
      send_request(MODE_ADD,    255, 32'hFFFF_FFFF, 1'b1);
      send_request(MODE_ADD,    0,   32'h0000_0000, 1'b0);
      send_request(MODE_ADD,    0,   32'hA5A5_5A5A, 1'b0);
      send_request(MODE_ADD,    0,   32'h1234_5678, 1'b0);
      send_request(MODE_GET,    0,   32'h0,         1'b0);
      send_request(MODE_GET,    1,   32'hFFFF_FFFF, 1'b1);
      send_request(MODE_GET,    3,   32'h0,         1'b0);
      send_request(MODE_GET,    4,   32'h0,         1'b0);  // just past the count
      send_request(MODE_GET,    255, 32'h0,         1'b0);
      send_request(MODE_REMOVE, 1,   32'h0,         1'b1);  // middle slot: freed
      send_request(MODE_GET,    1,   32'h0,         1'b0);  // freed slot: absent
      send_request(MODE_REMOVE, 1,   32'h0,         1'b1);
      send_request(MODE_REMOVE, 2,   32'h0,         1'b0);  // discard
      send_request(MODE_ADD,    0,   32'hDEAD_BEEF, 1'b0);  // reuses last freed
      send_request(MODE_ADD,    0,   32'hCAFE_F00D, 1'b0);
      send_request(MODE_REMOVE, 3,   32'h0,         1'b1);  // top slot: count shrinks
      send_request(MODE_GET,    3,   32'h0,         1'b0);
      send_request(MODE_NONE,   255, 32'hFFFF_FFFF, 1'b1);
      send_request(MODE_ADD,    0,   32'h8000_0001, 1'b0);
      send_request(MODE_GET,    2,   32'h0,         1'b0);
   endtask

   task automatic test_random_mix(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         random_request();
      end
      no_idle = 1'b0;
   endtask

   // Receiver holds off while the sender keeps offering back to back.
   task automatic test_output_stall();
      hold_off_len = 200;
      no_idle      = 1'b1;
      for (int i = 0; i < 30; i++) begin
         if (i % 3 == 0)
            send_request(MODE_ADD, 0, $urandom, 1'b0);
         else
            send_request(MODE_GET, pick_slot_index(), $urandom, 1'b0);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_fill_and_drain();
      while (!(high_water == SLOTS && free_top == 0))
         send_request(MODE_ADD, $urandom_range(0, 255), $urandom, 1'($urandom_range(0, 1)));
      repeat (3) send_request(MODE_ADD, 0, $urandom, 1'b0);  // full
      send_request(MODE_GET,    255, 32'h0, 1'b0);
      send_request(MODE_GET,    0,   32'h0, 1'b0);
      send_request(MODE_REMOVE, 255, 32'h0, 1'b1);
      send_request(MODE_GET,    255, 32'h0, 1'b0);
      send_request(MODE_ADD,    0,   $urandom, 1'b0);
      send_request(MODE_REMOVE, 100, 32'h0, 1'b1);
      send_request(MODE_REMOVE, 7,   32'h0, 1'b0);
      send_request(MODE_ADD,    0,   $urandom, 1'b0);
      send_request(MODE_ADD,    0,   $urandom, 1'b0);
      send_request(MODE_ADD,    0,   $urandom, 1'b0);
      send_request(MODE_GET,    255, 32'h0, 1'b0);
      repeat (60)
         send_request(MODE_REMOVE, pick_slot_index(), $urandom, 1'($urandom_range(0, 1)));
   endtask

   // Response checker
   always @(posedge clock) begin : check_rsp
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(rsp_type)-1:0];
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.result_index !== want.result_index) begin
               $error("result_index: expected %0d, got %0d",
                      want.result_index, got.result_index);
               error_count++;
            end
            if (got.result_data !== want.result_data) begin
               $error("result_data: expected %h, got %h", want.result_data, got.result_data);
               error_count++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock)
      if (!reset && req_tvalid && !req_tready) input_stall_cycles++;

   // Receiver: random holds, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_len) @(posedge clock);
            hold_off_len = 0;
            rsp_tready <= 1'b1;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (idle_len()) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      free_top   = 0;
      high_water = 0;
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix(300);
      test_output_stall();
      test_fill_and_drain();
      test_random_mix(120);

      req_tvalid <= 1'b0;
      wait_for_responses();
      repeat (10) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d responses never arrived", pending_rsp.size());
         error_count++;
      end

      $display("Requests: %0d add, %0d get, %0d remove, %0d unused mode; input stalled %0d cycles",
               op_count[MODE_ADD], op_count[MODE_GET], op_count[MODE_REMOVE],
               op_count[MODE_NONE], input_stall_cycles);
      $display("Statuses: %0d ok, %0d full, %0d out of range, %0d not occupied",
               status_count[STATUS_OK], status_count[STATUS_FULL],
               status_count[STATUS_RANGE], status_count[STATUS_ABSENT]);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
